/* rtl/ipr_pkg.sv */
package ipr_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 9;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_H  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_W  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_H = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_W = 3'd5;

   localparam logic [1:0] MODE_NEAREST = 2'd0;
   localparam logic [1:0] MODE_LINEAR  = 2'd1;
   localparam logic [1:0] MODE_AREA    = 2'd2;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_COMPUTE = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [7:0]         row;
      logic [7:0]         col;
      logic signed [15:0] sample;
   } ipr_req_type;

   typedef struct packed {
      logic signed [15:0] out_value;
      logic               bad_position;
   } ipr_rsp_type;

endpackage

/* rtl/image_plane_resampler.sv */
// Image plane resampler.
// Items enter on start/req_item and are taken at a clock edge where start is
// high and busy is low. A load item writes one sample into the plane store
// and gives no result. A compute item gives exactly one result on rsp_data,
// marked by rsp_valid for a single cycle; the receiver cannot stall, so the
// result must be taken in that cycle.
// Configuration registers are written through csr_we/csr_addr/csr_wdata.
// Every write, and reset, starts a recomputation of both scales in the shared
// restoring divider, which keeps busy high until both scales are done.
// A position out of range is answered in the cycle after acceptance. Nearest
// makes one store read; bilinear makes four store reads through the single
// read port and five passes through the shared multiplier. Area averaging
// runs the divider five times, plus one store read per sample of the window.
// One item is worked on at a time. Reset clears control state; the plane
// store is not cleared and must be loaded before it is read.
module image_plane_resampler #(
   parameter int MAX_HEIGHT  = 256,
   parameter int MAX_WIDTH   = 256,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  ipr_pkg::ipr_req_type               req_item,
   output logic                               rsp_valid,
   output ipr_pkg::ipr_rsp_type               rsp_data,
   input  logic                               csr_we,
   input  logic [ipr_pkg::CSR_IDX_W-1:0]      csr_addr,
   input  logic [ipr_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ipr_pkg::*;

   localparam int SB     = SAMPLE_BITS;
   localparam int RW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int HDW    = $clog2(MAX_HEIGHT + 1);
   localparam int WDW    = $clog2(MAX_WIDTH + 1);
   localparam int H_LIM  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
   localparam int W_LIM  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int MEM_AW = RW + CW;
   localparam int CNT_W  = $clog2(MAX_HEIGHT * MAX_WIDTH + 1);
   localparam int SUMW   = SB + CNT_W;
   localparam int DN_W   = (SUMW + 1 > 29) ? SUMW + 1 : 29;
   localparam int DEN_W  = (CNT_W > 9) ? CNT_W : 9;
   localparam int DCW    = $clog2(DN_W + 1);
   localparam int MAW    = SB + 19;
   localparam int MBW    = 18;
   localparam int MPW    = MAW + MBW;
   localparam int PW     = 34;
   localparam int TW     = SB + 17;
   localparam int ACW    = SB + 36;
   localparam int RSW    = DN_W + 2;
   localparam int STW    = 6;

   localparam logic [ACW-1:0] LIN_HALF = ACW'(64'h8000_0000);

   localparam logic [STW-1:0] ST_IDLE  = 6'd0;
   localparam logic [STW-1:0] ST_SCV   = 6'd1;
   localparam logic [STW-1:0] ST_SCVW  = 6'd2;
   localparam logic [STW-1:0] ST_SCH   = 6'd3;
   localparam logic [STW-1:0] ST_SCHW  = 6'd4;
   localparam logic [STW-1:0] ST_POSY  = 6'd5;
   localparam logic [STW-1:0] ST_POSX  = 6'd6;
   localparam logic [STW-1:0] ST_POSXD = 6'd7;
   localparam logic [STW-1:0] ST_NRD   = 6'd8;
   localparam logic [STW-1:0] ST_NOUT  = 6'd9;
   localparam logic [STW-1:0] ST_L00   = 6'd10;
   localparam logic [STW-1:0] ST_L01   = 6'd11;
   localparam logic [STW-1:0] ST_L10   = 6'd12;
   localparam logic [STW-1:0] ST_L11   = 6'd13;
   localparam logic [STW-1:0] ST_LTOP  = 6'd14;
   localparam logic [STW-1:0] ST_LBOT  = 6'd15;
   localparam logic [STW-1:0] ST_LBOTD = 6'd16;
   localparam logic [STW-1:0] ST_LDY   = 6'd17;
   localparam logic [STW-1:0] ST_LACC  = 6'd18;
   localparam logic [STW-1:0] ST_AM0   = 6'd19;
   localparam logic [STW-1:0] ST_AD0   = 6'd20;
   localparam logic [STW-1:0] ST_AD0W  = 6'd21;
   localparam logic [STW-1:0] ST_AD1   = 6'd22;
   localparam logic [STW-1:0] ST_AD1W  = 6'd23;
   localparam logic [STW-1:0] ST_AD2   = 6'd24;
   localparam logic [STW-1:0] ST_AD2W  = 6'd25;
   localparam logic [STW-1:0] ST_AD3   = 6'd26;
   localparam logic [STW-1:0] ST_AD3W  = 6'd27;
   localparam logic [STW-1:0] ST_ACNT  = 6'd28;
   localparam logic [STW-1:0] ST_ARD   = 6'd29;
   localparam logic [STW-1:0] ST_ALAST = 6'd30;
   localparam logic [STW-1:0] ST_ADIV  = 6'd31;
   localparam logic [STW-1:0] ST_ADIVW = 6'd32;

   function automatic logic signed [15:0] sat16(input logic signed [RSW-1:0] v);
      if (v > 32767) begin
         return 16'h7FFF;
      end else if (v < -32768) begin
         return 16'h8000;
      end
      return v[15:0];
   endfunction

   logic [STW-1:0]           state_ff, state_in;
   logic                     dirty_ff, dirty_in;
   logic [1:0]               mode_ff, mode_in;
   logic                     align_ff, align_in;
   logic [8:0]               in_h_ff, in_h_in, in_w_ff, in_w_in;
   logic [8:0]               out_h_ff, out_h_in, out_w_ff, out_w_in;
   logic [23:0]              scale_v_ff, scale_v_in, scale_h_ff, scale_h_in;
   logic [7:0]               row_ff, row_in, col_ff, col_in;
   logic signed [PW-1:0]     pos_y_ff, pos_y_in, pos_x_ff, pos_x_in;
   logic signed [SB-1:0]     sa_ff, sa_in, sb_ff, sb_in, sc_ff, sc_in, sd_ff, sd_in;
   logic signed [TW-1:0]     top_ff, top_in, bot_ff, bot_in;
   logic [HDW-1:0]           h0_ff, h0_in, h1_ff, h1_in, r_ff, r_in;
   logic [WDW-1:0]           w0_ff, w0_in, w1_ff, w1_in, c_ff, c_in;
   logic signed [SUMW-1:0]   sum_ff, sum_in;
   logic                     rd_issued_ff, rd_issued_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   ipr_rsp_type              rsp_data_ff, rsp_data_in;

   logic                     mul_ld;
   logic signed [MAW-1:0]    mul_a;
   logic signed [MBW-1:0]    mul_b;
   logic signed [MPW-1:0]    mul_p_ff;

   logic                     dv_start;
   logic [DN_W-1:0]          dv_num;
   logic [DEN_W-1:0]         dv_den;
   logic [DEN_W-1:0]         dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [DN_W-1:0]          dv_quo_ff, dv_quo_in;
   logic [DCW-1:0]           dv_cnt_ff, dv_cnt_in;
   logic [DEN_W:0]           dv_shift, dv_diff;
   logic                     dv_done;

   logic signed [SB-1:0]     plane_mem [0:(2**MEM_AW)-1];
   logic signed [SB-1:0]     rd_data_ff;
   logic                     mem_we;
   logic [MEM_AW-1:0]        wa, ra;
   logic signed [SB-1:0]     smp_ext;

   logic [HDW-1:0]           ih;
   logic [WDW-1:0]           iw;
   logic [8:0]               oh, ow;
   logic [HDW-1:0]           sv_num;
   logic [WDW-1:0]           sh_num;
   logic [8:0]               sv_den, sh_den;
   logic                     sv_zero, sh_zero;
   logic signed [PW-1:0]     pos_calc;

   logic signed [PW-1:0]     ny_t, nx_t, hi_y, hi_x, py, px;
   logic [RW-1:0]            ny, y0, y1;
   logic [CW-1:0]            nx, x0, x1;
   logic [HDW-1:0]           y0p;
   logic [WDW-1:0]           x0p;
   logic [15:0]              fy, fx;

   logic [ACW-1:0]           lin_acc;
   logic [CNT_W-1:0]         win_cnt;
   logic [SUMW-1:0]          sum_mag;
   logic signed [RSW-1:0]    area_q;

   assign busy      = (state_ff != ST_IDLE) || dirty_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign ih = (in_h_ff == 9'd0) ? HDW'(1) :
               (in_h_ff > H_LIM) ? HDW'(H_LIM) : HDW'(in_h_ff);
   assign iw = (in_w_ff == 9'd0) ? WDW'(1) :
               (in_w_ff > W_LIM) ? WDW'(W_LIM) : WDW'(in_w_ff);
   assign oh = (out_h_ff == 9'd0) ? 9'd1 : (out_h_ff > 9'd256) ? 9'd256 : out_h_ff;
   assign ow = (out_w_ff == 9'd0) ? 9'd1 : (out_w_ff > 9'd256) ? 9'd256 : out_w_ff;

   assign sv_num  = align_ff ? ih - HDW'(1) : ih;
   assign sh_num  = align_ff ? iw - WDW'(1) : iw;
   assign sv_den  = align_ff ? oh - 9'd1 : oh;
   assign sh_den  = align_ff ? ow - 9'd1 : ow;
   assign sv_zero = align_ff && (oh <= 9'd1);
   assign sh_zero = align_ff && (ow <= 9'd1);

   assign pos_calc = align_ff ? $signed({2'b00, mul_p_ff[31:0]}) :
                                $signed({2'b00, mul_p_ff[32:1]}) - 34'sd32768;

   assign ny_t = pos_y_ff + 34'sd32768;
   assign nx_t = pos_x_ff + 34'sd32768;
   assign ny = (pos_y_ff < 0) ? '0 :
               (ny_t[PW-1:16] > 18'(ih - HDW'(1))) ? RW'(ih - HDW'(1)) : RW'(ny_t[PW-1:16]);
   assign nx = (pos_x_ff < 0) ? '0 :
               (nx_t[PW-1:16] > 18'(iw - WDW'(1))) ? CW'(iw - WDW'(1)) : CW'(nx_t[PW-1:16]);

   assign hi_y = $signed(PW'({ih - HDW'(1), 16'h0000}));
   assign hi_x = $signed(PW'({iw - WDW'(1), 16'h0000}));
   assign py   = (pos_y_ff < 0) ? '0 : (pos_y_ff > hi_y) ? hi_y : pos_y_ff;
   assign px   = (pos_x_ff < 0) ? '0 : (pos_x_ff > hi_x) ? hi_x : pos_x_ff;
   assign y0   = py[16 +: RW];
   assign x0   = px[16 +: CW];
   assign fy   = py[15:0];
   assign fx   = px[15:0];
   assign y0p  = HDW'(y0) + HDW'(1);
   assign x0p  = WDW'(x0) + WDW'(1);
   assign y1   = (y0p < ih) ? RW'(y0p) : RW'(ih - HDW'(1));
   assign x1   = (x0p < iw) ? CW'(x0p) : CW'(iw - WDW'(1));

   assign lin_acc = (ACW'(top_ff) <<< 16) + ACW'(mul_p_ff) + LIN_HALF;
   assign win_cnt = mul_p_ff[CNT_W-1:0];
   assign sum_mag = (sum_ff < 0) ? SUMW'(-sum_ff) : SUMW'(sum_ff);
   assign area_q  = (sum_ff < 0) ? -$signed(RSW'(dv_quo_ff)) : $signed(RSW'(dv_quo_ff));

   assign smp_ext = SB'(req_item.sample);
   assign wa      = {RW'(req_item.row), CW'(req_item.col)};

   assign dv_shift = {dv_rem_ff, dv_quo_ff[DN_W-1]};
   assign dv_diff  = dv_shift - {1'b0, dv_den_ff};
   assign dv_done  = (dv_cnt_ff == '0);

   always_comb begin
      state_in     = state_ff;
      dirty_in     = dirty_ff;
      mode_in      = mode_ff;
      align_in     = align_ff;
      in_h_in      = in_h_ff;
      in_w_in      = in_w_ff;
      out_h_in     = out_h_ff;
      out_w_in     = out_w_ff;
      scale_v_in   = scale_v_ff;
      scale_h_in   = scale_h_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pos_y_in     = pos_y_ff;
      pos_x_in     = pos_x_ff;
      sa_in        = sa_ff;
      sb_in        = sb_ff;
      sc_in        = sc_ff;
      sd_in        = sd_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      h0_in        = h0_ff;
      h1_in        = h1_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      r_in         = r_ff;
      c_in         = c_ff;
      sum_in       = sum_ff;
      rd_issued_in = (state_ff == ST_ARD);
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mul_ld       = 1'b0;
      mul_a        = '0;
      mul_b        = '0;
      dv_start     = 1'b0;
      dv_num       = '0;
      dv_den       = '0;
      mem_we       = 1'b0;
      ra           = '0;

      if (rd_issued_ff) begin
         sum_in = sum_ff + SUMW'(rd_data_ff);
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (start && !busy) begin
               if (req_item.req_type == REQ_LOAD) begin
                  mem_we = (req_item.row < MAX_HEIGHT) && (req_item.col < MAX_WIDTH);
               end else if ((req_item.row >= oh) || (req_item.col >= ow)) begin
                  rsp_valid_in             = 1'b1;
                  rsp_data_in.out_value    = '0;
                  rsp_data_in.bad_position = 1'b1;
               end else begin
                  row_in   = req_item.row;
                  col_in   = req_item.col;
                  state_in = (mode_ff == MODE_AREA) ? ST_AM0 : ST_POSY;
               end
            end else if (dirty_ff && !csr_we) begin
               state_in = ST_SCV;
            end
         end
         ST_SCV: begin
            if (sv_zero) begin
               scale_v_in = '0;
               state_in   = ST_SCH;
            end else begin
               dv_start = 1'b1;
               dv_num   = (DN_W'(sv_num) << 16) + DN_W'(sv_den >> 1);
               dv_den   = DEN_W'(sv_den);
               state_in = ST_SCVW;
            end
         end
         ST_SCVW: begin
            if (dv_done) begin
               scale_v_in = (dv_quo_ff > DN_W'(24'hFFFFFF)) ? 24'hFFFFFF : dv_quo_ff[23:0];
               state_in   = ST_SCH;
            end
         end
         ST_SCH: begin
            if (sh_zero) begin
               scale_h_in = '0;
               dirty_in   = 1'b0;
               state_in   = ST_IDLE;
            end else begin
               dv_start = 1'b1;
               dv_num   = (DN_W'(sh_num) << 16) + DN_W'(sh_den >> 1);
               dv_den   = DEN_W'(sh_den);
               state_in = ST_SCHW;
            end
         end
         ST_SCHW: begin
            if (dv_done) begin
               scale_h_in = (dv_quo_ff > DN_W'(24'hFFFFFF)) ? 24'hFFFFFF : dv_quo_ff[23:0];
               dirty_in   = 1'b0;
               state_in   = ST_IDLE;
            end
         end
         ST_POSY: begin
            mul_ld   = 1'b1;
            mul_a    = MAW'(scale_v_ff);
            mul_b    = align_ff ? MBW'(row_ff) : MBW'({row_ff, 1'b1});
            state_in = ST_POSX;
         end
         ST_POSX: begin
            pos_y_in = pos_calc;
            mul_ld   = 1'b1;
            mul_a    = MAW'(scale_h_ff);
            mul_b    = align_ff ? MBW'(col_ff) : MBW'({col_ff, 1'b1});
            state_in = ST_POSXD;
         end
         ST_POSXD: begin
            pos_x_in = pos_calc;
            state_in = (mode_ff == MODE_NEAREST) ? ST_NRD : ST_L00;
         end
         ST_NRD: begin
            ra       = {ny, nx};
            state_in = ST_NOUT;
         end
         ST_NOUT: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_value    = sat16(RSW'(rd_data_ff));
            rsp_data_in.bad_position = 1'b0;
            state_in                 = ST_IDLE;
         end
         ST_L00: begin
            ra       = {y0, x0};
            state_in = ST_L01;
         end
         ST_L01: begin
            ra       = {y0, x1};
            sa_in    = rd_data_ff;
            state_in = ST_L10;
         end
         ST_L10: begin
            ra       = {y1, x0};
            sb_in    = rd_data_ff;
            state_in = ST_L11;
         end
         ST_L11: begin
            ra       = {y1, x1};
            sc_in    = rd_data_ff;
            state_in = ST_LTOP;
         end
         ST_LTOP: begin
            sd_in    = rd_data_ff;
            mul_ld   = 1'b1;
            mul_a    = MAW'(sb_ff) - MAW'(sa_ff);
            mul_b    = MBW'(fx);
            state_in = ST_LBOT;
         end
         ST_LBOT: begin
            top_in   = (TW'(sa_ff) <<< 16) + TW'(mul_p_ff);
            mul_ld   = 1'b1;
            mul_a    = MAW'(sd_ff) - MAW'(sc_ff);
            mul_b    = MBW'(fx);
            state_in = ST_LBOTD;
         end
         ST_LBOTD: begin
            bot_in   = (TW'(sc_ff) <<< 16) + TW'(mul_p_ff);
            state_in = ST_LDY;
         end
         ST_LDY: begin
            mul_ld   = 1'b1;
            mul_a    = MAW'(bot_ff) - MAW'(top_ff);
            mul_b    = MBW'(fy);
            state_in = ST_LACC;
         end
         ST_LACC: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.out_value    = sat16(RSW'($signed(lin_acc[ACW-1:32])));
            rsp_data_in.bad_position = 1'b0;
            state_in                 = ST_IDLE;
         end
         ST_AM0: begin
            mul_ld   = 1'b1;
            mul_a    = MAW'(ih);
            mul_b    = MBW'(row_ff);
            state_in = ST_AD0;
         end
         ST_AD0: begin
            dv_start = 1'b1;
            dv_num   = DN_W'(mul_p_ff);
            dv_den   = DEN_W'(oh);
            mul_ld   = 1'b1;
            mul_a    = MAW'(ih);
            mul_b    = MBW'(row_ff) + MBW'(1);
            state_in = ST_AD0W;
         end
         ST_AD0W: begin
            if (dv_done) begin
               h0_in    = HDW'(dv_quo_ff);
               state_in = ST_AD1;
            end
         end
         ST_AD1: begin
            dv_start = 1'b1;
            dv_num   = DN_W'(mul_p_ff) + DN_W'(oh) - DN_W'(1);
            dv_den   = DEN_W'(oh);
            mul_ld   = 1'b1;
            mul_a    = MAW'(iw);
            mul_b    = MBW'(col_ff);
            state_in = ST_AD1W;
         end
         ST_AD1W: begin
            if (dv_done) begin
               h1_in    = (dv_quo_ff > DN_W'(ih)) ? ih : HDW'(dv_quo_ff);
               state_in = ST_AD2;
            end
         end
         ST_AD2: begin
            dv_start = 1'b1;
            dv_num   = DN_W'(mul_p_ff);
            dv_den   = DEN_W'(ow);
            mul_ld   = 1'b1;
            mul_a    = MAW'(iw);
            mul_b    = MBW'(col_ff) + MBW'(1);
            state_in = ST_AD2W;
         end
         ST_AD2W: begin
            if (dv_done) begin
               w0_in    = WDW'(dv_quo_ff);
               state_in = ST_AD3;
            end
         end
         ST_AD3: begin
            dv_start = 1'b1;
            dv_num   = DN_W'(mul_p_ff) + DN_W'(ow) - DN_W'(1);
            dv_den   = DEN_W'(ow);
            state_in = ST_AD3W;
         end
         ST_AD3W: begin
            if (dv_done) begin
               w1_in    = (dv_quo_ff > DN_W'(iw)) ? iw : WDW'(dv_quo_ff);
               state_in = ST_ACNT;
            end
         end
         ST_ACNT: begin
            mul_ld   = 1'b1;
            mul_a    = MAW'(h1_ff - h0_ff);
            mul_b    = MBW'(w1_ff - w0_ff);
            r_in     = h0_ff;
            c_in     = w0_ff;
            sum_in   = '0;
            state_in = ST_ARD;
         end
         ST_ARD: begin
            ra = {r_ff[RW-1:0], c_ff[CW-1:0]};
            if ((r_ff == h1_ff - HDW'(1)) && (c_ff == w1_ff - WDW'(1))) begin
               state_in = ST_ALAST;
            end else if (c_ff == w1_ff - WDW'(1)) begin
               c_in = w0_ff;
               r_in = r_ff + HDW'(1);
            end else begin
               c_in = c_ff + WDW'(1);
            end
         end
         ST_ALAST: begin
            state_in = ST_ADIV;
         end
         ST_ADIV: begin
            dv_start = 1'b1;
            dv_num   = DN_W'(sum_mag) + DN_W'(win_cnt >> 1);
            dv_den   = DEN_W'(win_cnt);
            state_in = ST_ADIVW;
         end
         ST_ADIVW: begin
            if (dv_done) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.out_value    = sat16(area_q);
               rsp_data_in.bad_position = 1'b0;
               state_in                 = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         dirty_in = 1'b1;
         unique case (csr_addr)
            CSR_MODE:  mode_in  = csr_wdata[1:0];
            CSR_ALIGN: align_in = csr_wdata[0];
            CSR_IN_H:  in_h_in  = csr_wdata;
            CSR_IN_W:  in_w_in  = csr_wdata;
            CSR_OUT_H: out_h_in = csr_wdata;
            CSR_OUT_W: out_w_in = csr_wdata;
            default: begin
            end
         endcase
         if ((state_ff == ST_SCV) || (state_ff == ST_SCVW) ||
             (state_ff == ST_SCH) || (state_ff == ST_SCHW)) begin
            state_in = ST_IDLE;
         end
      end
   end

   always_comb begin
      dv_rem_in = dv_rem_ff;
      dv_quo_in = dv_quo_ff;
      dv_den_in = dv_den_ff;
      dv_cnt_in = dv_cnt_ff;
      if (dv_start) begin
         dv_rem_in = '0;
         dv_quo_in = dv_num;
         dv_den_in = dv_den;
         dv_cnt_in = DCW'(DN_W);
      end else if (!dv_done) begin
         dv_cnt_in = dv_cnt_ff - DCW'(1);
         if (!dv_diff[DEN_W]) begin
            dv_rem_in = dv_diff[DEN_W-1:0];
            dv_quo_in = {dv_quo_ff[DN_W-2:0], 1'b1};
         end else begin
            dv_rem_in = dv_shift[DEN_W-1:0];
            dv_quo_in = {dv_quo_ff[DN_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         plane_mem[wa] <= smp_ext;
      end
      rd_data_ff <= plane_mem[ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dirty_ff     <= 1'b1;
         mode_ff      <= MODE_LINEAR;
         align_ff     <= 1'b0;
         in_h_ff      <= 9'd1;
         in_w_ff      <= 9'd1;
         out_h_ff     <= 9'd1;
         out_w_ff     <= 9'd1;
         scale_v_ff   <= '0;
         scale_h_ff   <= '0;
         dv_cnt_ff    <= '0;
         rd_issued_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dirty_ff     <= dirty_in;
         mode_ff      <= mode_in;
         align_ff     <= align_in;
         in_h_ff      <= in_h_in;
         in_w_ff      <= in_w_in;
         out_h_ff     <= out_h_in;
         out_w_ff     <= out_w_in;
         scale_v_ff   <= scale_v_in;
         scale_h_ff   <= scale_h_in;
         dv_cnt_ff    <= dv_cnt_in;
         rd_issued_ff <= rd_issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff      <= row_in;
      col_ff      <= col_in;
      pos_y_ff    <= pos_y_in;
      pos_x_ff    <= pos_x_in;
      sa_ff       <= sa_in;
      sb_ff       <= sb_in;
      sc_ff       <= sc_in;
      sd_ff       <= sd_in;
      top_ff      <= top_in;
      bot_ff      <= bot_in;
      h0_ff       <= h0_in;
      h1_ff       <= h1_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      r_ff        <= r_in;
      c_ff        <= c_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
      dv_rem_ff   <= dv_rem_in;
      dv_quo_ff   <= dv_quo_in;
      dv_den_ff   <= dv_den_in;
      if (mul_ld) begin
         mul_p_ff <= mul_a * mul_b;
      end
   end

endmodule

/* rtl/ipr_chk.sv */
module ipr_chk (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input ipr_pkg::ipr_req_type  req_item,
   input logic                  rsp_valid,
   input ipr_pkg::ipr_rsp_type  rsp_data,
   input logic                  csr_we
);
   import ipr_pkg::*;

   // Scales are rebuilt after reset, so no item may be taken right away.
   a_reset_busy: assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   a_csr_busy: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("busy low right after a register write");

   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_item.req_type == REQ_LOAD)) |=> !rsp_valid)
      else $error("result strobe after a load item");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy || start))
      else $error("result strobe without an item in flight");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bad_position) |-> (rsp_data.out_value == 16'sd0))
      else $error("nonzero value with a bad position");

endmodule

bind image_plane_resampler ipr_chk u_ipr_chk (.*);

/* tb/sv/testbench.sv */
module testbench;
   import ipr_pkg::*;

   typedef enum int {OP_ITEM, OP_CSR, OP_SYNC} op_kind_type;

   typedef struct {
      op_kind_type             kind;
      ipr_req_type             item;
      logic [CSR_IDX_W-1:0]    addr;
      logic [CSR_DATA_W-1:0]   data;
      int                      idle_pct;
   } pending_op_type;

   localparam int SETTLE_CYCLES = 120;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   ipr_req_type           req_item = '0;
   logic                  rsp_valid;
   ipr_rsp_type           rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   pending_op_type op_queue[$];
   ipr_rsp_type   pixel_queue[$];
   int            error_count = 0;
   int            quiet_cycles = 0;
   int            idle_pct = 0;
   bit            stimulus_done = 0;

   logic signed [15:0] plane[0:65535];
   logic [1:0]    reg_mode = MODE_LINEAR;
   logic          reg_align = 1'b0;
   logic [8:0]    reg_in_h = 9'd1, reg_in_w = 9'd1, reg_out_h = 9'd1, reg_out_w = 9'd1;
   longint        scale_v = 0, scale_h = 0;

   image_plane_resampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we), .csr_addr(csr_addr),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic longint eff_dim(logic [8:0] v);
      if (v == 0) return 1;
      if (v > 256) return 256;
      return v;
   endfunction

   function automatic longint make_scale(longint in_n, longint out_n, bit ac);
      longint num, den, s;
      if (ac) begin
         if (out_n <= 1) return 0;
         num = in_n - 1;
         den = out_n - 1;
      end else begin
         num = in_n;
         den = out_n;
      end
      s = ((num << 16) + den / 2) / den;
      if (s > 64'hFFFFFF) s = 64'hFFFFFF;
      return s;
   endfunction

   function automatic longint source_pos(longint o, longint sc, bit ac);
      if (ac) return o * sc;
      return (((2 * o + 1) * sc) >> 1) - 32768;
   endfunction

   function automatic longint nearest_idx(longint p, longint n);
      longint i;
      if (p < 0) return 0;
      i = (p + 32768) >> 16;
      if (i > n - 1) i = n - 1;
      return i;
   endfunction

   function automatic longint clamp_pos(longint p, longint n);
      if (p < 0) return 0;
      if (p > (n - 1) * 65536) return (n - 1) * 65536;
      return p;
   endfunction

   function automatic longint pix(longint r, longint c);
      return longint'(plane[r * 256 + c]);
   endfunction

   function automatic longint blend_pixel(longint orow, longint ocol, longint ih, longint iw);
      longint py, px, y0, x0, y1, x1, fy, fx, top, bot, acc;
      py = clamp_pos(source_pos(orow, scale_v, reg_align), ih);
      px = clamp_pos(source_pos(ocol, scale_h, reg_align), iw);
      y0 = py >> 16;
      x0 = px >> 16;
      y1 = (y0 + 1 < ih) ? y0 + 1 : ih - 1;
      x1 = (x0 + 1 < iw) ? x0 + 1 : iw - 1;
      fy = py & 16'hFFFF;
      fx = px & 16'hFFFF;
      top = pix(y0, x0) * (65536 - fx) + pix(y0, x1) * fx;
      bot = pix(y1, x0) * (65536 - fx) + pix(y1, x1) * fx;
      acc = top * (65536 - fy) + bot * fy + (64'sd1 <<< 31);
      return acc >>> 32;
   endfunction

   function automatic longint window_average(longint orow, longint ocol, longint ih,
                                             longint iw, longint oh, longint ow);
      longint h0, h1, w0, w1, sum, count, mag, q;
      h0 = (orow * ih) / oh;
      h1 = ((orow + 1) * ih + oh - 1) / oh;
      w0 = (ocol * iw) / ow;
      w1 = ((ocol + 1) * iw + ow - 1) / ow;
      sum = 0;
      count = 0;
      if (h1 > ih) h1 = ih;
      if (w1 > iw) w1 = iw;
      for (longint r = h0; r < h1; r++)
         for (longint c = w0; c < w1; c++) begin
            sum += pix(r, c);
            count++;
         end
      if (count == 0) return 0;
      mag = (sum < 0) ? -sum : sum;
      q = (mag + count / 2) / count;
      return (sum < 0) ? -q : q;
   endfunction

   function automatic void write_register(logic [CSR_IDX_W-1:0] idx, logic [8:0] val);
      case (idx)
         CSR_MODE:  reg_mode = val[1:0];
         CSR_ALIGN: reg_align = val[0];
         CSR_IN_H:  reg_in_h = val;
         CSR_IN_W:  reg_in_w = val;
         CSR_OUT_H: reg_out_h = val;
         CSR_OUT_W: reg_out_w = val;
         default: return;
      endcase
      scale_v = make_scale(eff_dim(reg_in_h), eff_dim(reg_out_h), reg_align);
      scale_h = make_scale(eff_dim(reg_in_w), eff_dim(reg_out_w), reg_align);
   endfunction

   function automatic void predict_item(ipr_req_type it);
      longint ih, iw, oh, ow, v;
      ipr_rsp_type exp_pix;
      ih = eff_dim(reg_in_h);
      iw = eff_dim(reg_in_w);
      oh = eff_dim(reg_out_h);
      ow = eff_dim(reg_out_w);
      if (it.req_type == REQ_LOAD) begin
         plane[{it.row, it.col}] = it.sample;
         return;
      end
      exp_pix = '0;
      if (it.row >= oh || it.col >= ow) begin
         exp_pix.bad_position = 1'b1;
      end else begin
         if (reg_mode == MODE_NEAREST)
            v = pix(nearest_idx(source_pos(it.row, scale_v, reg_align), ih),
                    nearest_idx(source_pos(it.col, scale_h, reg_align), iw));
         else if (reg_mode == MODE_AREA)
            v = window_average(it.row, it.col, ih, iw, oh, ow);
         else
            v = blend_pixel(it.row, it.col, ih, iw);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         exp_pix.out_value = v[15:0];
      end
      pixel_queue.push_back(exp_pix);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Driver: one nonblocking assignment per signal per edge.
   logic        nxt_start, nxt_we;
   ipr_req_type nxt_item;
   logic [CSR_IDX_W-1:0]  nxt_addr;
   logic [CSR_DATA_W-1:0] nxt_data;
   bit          taken;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_we <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         taken = start && !busy;
         if (taken) predict_item(req_item);
         nxt_start = start && !taken;
         nxt_item = req_item;
         nxt_we = 1'b0;
         nxt_addr = csr_addr;
         nxt_data = csr_wdata;
         if (!nxt_start && !csr_we && op_queue.size() > 0) begin
            case (op_queue[0].kind)
               OP_ITEM: begin
                  if ($urandom_range(0, 99) >= idle_pct) begin
                     nxt_start = 1'b1;
                     nxt_item = op_queue[0].item;
                     void'(op_queue.pop_front());
                  end
               end
               OP_SYNC: begin
                  if (!taken && !busy && pixel_queue.size() == 0 &&
                      quiet_cycles >= SETTLE_CYCLES) begin
                     idle_pct = op_queue[0].idle_pct;
                     void'(op_queue.pop_front());
                  end
               end
               default: begin
                  if (!taken && !busy) begin
                     nxt_we = 1'b1;
                     nxt_addr = op_queue[0].addr;
                     nxt_data = op_queue[0].data;
                     write_register(op_queue[0].addr, op_queue[0].data);
                     void'(op_queue.pop_front());
                  end
               end
            endcase
         end
         start <= nxt_start;
         req_item <= nxt_item;
         csr_we <= nxt_we;
         csr_addr <= nxt_addr;
         csr_wdata <= nxt_data;
         quiet_cycles <= (taken || rsp_valid || csr_we) ? 0 : quiet_cycles + 1;
      end
   end

   // Monitor.
   ipr_rsp_type want;
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pixel_queue.size() == 0) begin
            report_mismatch("result with none expected");
         end else begin
            want = pixel_queue.pop_front();
            if (rsp_data.bad_position !== want.bad_position)
               report_mismatch($sformatf("bad_position %b, expected %b",
                                         rsp_data.bad_position, want.bad_position));
            if (rsp_data.out_value !== want.out_value)
               report_mismatch($sformatf("out_value %0d, expected %0d",
                                         rsp_data.out_value, want.out_value));
         end
      end
   end

   task automatic push_item(logic kind, int r, int c, int s);
      pending_op_type op;
      op = '{OP_ITEM, '0, '0, '0, 0};
      op.item.req_type = kind;
      op.item.row = r[7:0];
      op.item.col = c[7:0];
      op.item.sample = s[15:0];
      op_queue.push_back(op);
   endtask

   task automatic push_phase(int mode, int ac, int ih, int iw, int oh, int ow, int idle,
                             int n_rand);
      pending_op_type op;
      int eih, eiw, eoh, eow, r, c, pick;
      op = '{OP_SYNC, '0, '0, '0, idle};
      op_queue.push_back(op);
      op.kind = OP_CSR;
      op.addr = CSR_MODE;  op.data = CSR_DATA_W'(mode); op_queue.push_back(op);
      op.addr = CSR_ALIGN; op.data = CSR_DATA_W'(ac);   op_queue.push_back(op);
      op.addr = CSR_IN_H;  op.data = CSR_DATA_W'(ih);   op_queue.push_back(op);
      op.addr = CSR_IN_W;  op.data = CSR_DATA_W'(iw);   op_queue.push_back(op);
      op.addr = CSR_OUT_H; op.data = CSR_DATA_W'(oh);   op_queue.push_back(op);
      op.addr = CSR_OUT_W; op.data = CSR_DATA_W'(ow);   op_queue.push_back(op);
      op.kind = OP_SYNC;
      op_queue.push_back(op);
      eih = int'(eff_dim(CSR_DATA_W'(ih)));
      eiw = int'(eff_dim(CSR_DATA_W'(iw)));
      eoh = int'(eff_dim(CSR_DATA_W'(oh)));
      eow = int'(eff_dim(CSR_DATA_W'(ow)));
      // Every sample of the input region is written before any compute item.
      for (r = 0; r < eih; r++)
         for (c = 0; c < eiw; c++) begin
            pick = $urandom_range(0, 9);
            push_item(REQ_LOAD, r, c, (pick == 0) ? 32767 : (pick == 1) ? -32768 :
                      $urandom_range(0, 65535));
         end
      push_item(REQ_COMPUTE, 0, 0, $urandom_range(0, 65535));
      push_item(REQ_COMPUTE, eoh - 1, eow - 1, $urandom_range(0, 65535));
      push_item(REQ_COMPUTE, 255, 255, 16'hFFFF);
      push_item(REQ_COMPUTE, 0, eow, 0);
      for (int k = 0; k < n_rand; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 12)
            push_item(REQ_LOAD, $urandom_range(0, eih - 1), $urandom_range(0, eiw - 1),
                      $urandom_range(0, 65535));
         else if (pick < 17)
            push_item(REQ_LOAD, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 65535));
         else if (pick < 25)
            push_item(REQ_COMPUTE, $urandom_range(0, 255), $urandom_range(0, 255),
                      $urandom_range(0, 65535));
         else
            push_item(REQ_COMPUTE, $urandom_range(0, eoh - 1), $urandom_range(0, eow - 1),
                      $urandom_range(0, 65535));
      end
   endtask

   initial begin
      push_phase(MODE_LINEAR,  0, 4, 4, 8, 8, 0, 40);
      push_phase(MODE_NEAREST, 0, 4, 4, 8, 8, 47, 40);
      push_phase(MODE_NEAREST, 1, 8, 8, 3, 5, 13, 40);
      push_phase(MODE_AREA,    0, 8, 6, 3, 4, 0, 30);
      push_phase(MODE_LINEAR,  1, 1, 16, 1, 40, 47, 40);
      push_phase(3,            0, 5, 5, 7, 3, 13, 30);
      push_phase(MODE_LINEAR,  0, 256, 1, 256, 1, 0, 30);
      push_phase(MODE_NEAREST, 1, 1, 256, 1, 256, 47, 30);
      push_phase(MODE_AREA,    1, 0, 300, 0, 2, 13, 10);
      push_phase(MODE_AREA,    0, 3, 3, 256, 256, 0, 40);
      push_phase(MODE_LINEAR,  0, 2, 2, 1, 1, 47, 20);
      push_phase(MODE_NEAREST, 0, 1, 1, 256, 256, 13, 20);
      push_phase(MODE_LINEAR,  1, 6, 7, 511, 300, 0, 30);
      for (int p = 0; p < 4; p++)
         push_phase($urandom_range(0, 3), $urandom_range(0, 1), $urandom_range(1, 6),
                    $urandom_range(1, 6), $urandom_range(1, 12), $urandom_range(1, 12),
                    (p % 3 == 0) ? 0 : (p % 3 == 1) ? 47 : 13, 6);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      while (op_queue.size() > 0 || start || pixel_queue.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pixel_queue.size() == 0) begin
         $display("status: pass");
      end else begin
         if (pixel_queue.size() > 0) report_mismatch("expected results never arrived");
         $display("status: fail");
      end
      $finish;
   end

   initial begin
      #30000000;
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
rtl/ipr_pkg.sv
rtl/image_plane_resampler.sv
rtl/ipr_chk.sv
tb/sv/testbench.sv
